// ----- design/lcmo_pkg.sv -----
// Shared types and constants for the LCM-with-overflow block.
`default_nettype none

package lcmo_pkg;

   localparam int FIELD_WIDTH        = 64;
   localparam int DATA_WIDTH_DEFAULT = 64;
   localparam logic SIGNED_MODE_RESET = 1'b1;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] operand_a;
      logic [FIELD_WIDTH-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] lcm_value;
      logic                   overflow;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic gcd_step;
      logic div_step;
      logic mul_step;
      logic out_load;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic zero;
      logic gcd_done;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- design/lcm_with_overflow_check_top.sv -----
// Top level of the LCM-with-overflow block: controller plus datapath.
`default_nettype none

// Computes lcm(|a|,|b|) as (|a| / gcd) * |b| on the low DATA_WIDTH bits of each
// operand, flagging overflow when the true multiple exceeds 2^W-1 (unsigned) or
// 2^(W-1)-1 (signed, csr bit = 1, the reset value); on overflow the low W bits of
// the product are returned. One word is worked at a time. Each accepted word runs
// through a binary GCD that takes one shift or subtract per cycle, then a
// bit-serial restoring division and a shift-add multiply over W bits, and the
// result is loaded into the output register. A zero operand skips the arithmetic.
// A finished word sits in the output register, and the next word is taken as
// soon as the state machine is idle again; it only waits for the output if that
// word is still stalled when the new result is ready. Write the mode register
// only while the block is idle.
module lcm_with_overflow_check_top #(
   parameter int DATA_WIDTH = lcmo_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  lcmo_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output lcmo_pkg::rsp_type    rsp_data,
   input  wire                  csr_wr_en,
   input  wire                  csr_wr_data
);

   lcmo_pkg::ctrl_cmd_type  cmd;
   lcmo_pkg::dp_status_type status;

   lcmo_ctrl #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lcmo_dpath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// ----- design/lcmo_dpath.sv -----
// Datapath: operand magnitudes, binary GCD, restoring divider, shift-add multiplier.
`default_nettype none

module lcmo_dpath #(
   parameter int DATA_WIDTH = lcmo_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_wr_en,
   input  wire                         csr_wr_data,
   input  lcmo_pkg::req_type           req_data,
   input  lcmo_pkg::ctrl_cmd_type      cmd,
   output lcmo_pkg::dp_status_type     status,
   output lcmo_pkg::rsp_type           rsp_data
);

   localparam int W = DATA_WIDTH;

   logic          signed_mode_ff;
   logic [W-1:0]  a_ff, a_in;     // a >> k, then quotient, then product low half
   logic [W-1:0]  b_ff;           // |b|, multiplicand
   logic [W-1:0]  u_ff, u_in;     // gcd working value, then product high half
   logic [W-1:0]  v_ff, v_in;     // gcd working value, ends as gcd >> k
   logic [W-1:0]  rem_ff, rem_in;
   logic          zero_ff;
   lcmo_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [W-1:0]  raw_a, raw_b, mag_a, mag_b;
   logic [W:0]    trial;
   logic          trial_ge;
   logic [W:0]    trial_diff;
   logic [W:0]    mul_sum;
   logic          ovf;

   always_comb begin
      raw_a = req_data.operand_a[W-1:0];
      raw_b = req_data.operand_b[W-1:0];
      mag_a = (signed_mode_ff && raw_a[W-1]) ? (~raw_a + 1'b1) : raw_a;
      mag_b = (signed_mode_ff && raw_b[W-1]) ? (~raw_b + 1'b1) : raw_b;
   end

   // restoring division step and multiply accumulate
   always_comb begin
      trial      = {rem_ff, a_ff[W-1]};
      trial_diff = trial - {1'b0, v_ff};
      trial_ge   = (trial >= {1'b0, v_ff});
      mul_sum    = {1'b0, u_ff} + (a_ff[0] ? {1'b0, b_ff} : {(W+1){1'b0}});
   end

   always_comb begin
      a_in   = a_ff;
      u_in   = u_ff;
      v_in   = v_ff;
      rem_in = rem_ff;
      if (cmd.load) begin
         a_in   = mag_a;
         u_in   = mag_a;
         v_in   = mag_b;
         rem_in = '0;
      end else if (cmd.gcd_step) begin
         if (!u_ff[0] && !v_ff[0]) begin
            u_in = u_ff >> 1;
            v_in = v_ff >> 1;
            a_in = a_ff >> 1;
         end else if (!u_ff[0]) begin
            u_in = u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_in = v_ff >> 1;
         end else if (u_ff >= v_ff) begin
            u_in = u_ff - v_ff;
         end else begin
            v_in = v_ff - u_ff;
         end
      end else if (cmd.div_step) begin
         rem_in = trial_ge ? trial_diff[W-1:0] : trial[W-1:0];
         a_in   = {a_ff[W-2:0], trial_ge};
      end else if (cmd.mul_step) begin
         // u_ff is zero when the GCD loop ends, so it starts as a clear high half
         u_in = mul_sum[W:1];
         a_in = {mul_sum[0], a_ff[W-1:1]};
      end
   end

   always_comb begin
      ovf         = (u_ff != '0) || (signed_mode_ff && a_ff[W-1]);
      rsp_data_in = rsp_data_ff;
      if (cmd.out_load) begin
         rsp_data_in.lcm_value = zero_ff ? '0 : lcmo_pkg::FIELD_WIDTH'(a_ff);
         rsp_data_in.overflow  = zero_ff ? 1'b0 : ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff <= lcmo_pkg::SIGNED_MODE_RESET;
      end else if (csr_wr_en) begin
         signed_mode_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
      if (cmd.load) begin
         b_ff    <= mag_b;
         zero_ff <= (mag_a == '0) || (mag_b == '0);
      end
   end

   assign status.zero     = zero_ff;
   assign status.gcd_done = (u_ff == '0);
   assign rsp_data        = rsp_data_ff;

endmodule

`default_nettype wire

// ----- design/lcmo_ctrl.sv -----
// Controller: sequences GCD, divide and multiply phases and owns both handshakes.
`default_nettype none

module lcmo_ctrl #(
   parameter int DATA_WIDTH = lcmo_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   input  lcmo_pkg::dp_status_type     status,
   output lcmo_pkg::ctrl_cmd_type      cmd
);

   localparam int CW = $clog2(DATA_WIDTH);
   localparam logic [CW-1:0] CNT_LAST = CW'(DATA_WIDTH - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_GCD  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (status.zero) begin
               state_in = ST_DONE;
            end else if (status.gcd_done) begin
               cnt_in   = CNT_LAST;
               state_in = ST_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               cnt_in   = CNT_LAST;
               state_in = ST_MUL;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.gcd_step, cmd.div_step, cmd.mul_step, cmd.out_load}))
      else $error("more than one datapath command at once");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result word overwritten while waiting");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_GCD))
      else $error("accepted word did not start the GCD phase");

   a_gcd_step_live: assert property (@(posedge clock) disable iff (reset)
      cmd.gcd_step |-> (!status.zero && !status.gcd_done))
      else $error("GCD step issued after the loop had ended");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the LCM-with-overflow block, with a predictor and scoreboard.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MOST_NEG   = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MOST_POS   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam int          HOLD_LEN   = 3000;   // long receiver hold-off, in cycles
   localparam int          SETTLE_LEN = 400;    // a little over the slowest word
   localparam int          PHASE_LEN  = 72;

   // Scoreboard: keeps its own copy of the mode bit, predicts each accepted
   // word and matches results against the oldest prediction.
   class lcm_scoreboard;
      bit                signed_mode = lcmo_pkg::SIGNED_MODE_RESET;
      lcmo_pkg::rsp_type predicted_lcm[$];
      int                errors = 0;

      function logic [63:0] magnitude(logic [63:0] v);
         if (signed_mode && v[63])
            return ~v + 64'd1;
         return v;
      endfunction

      function lcmo_pkg::rsp_type lcm_of(lcmo_pkg::req_type w);
         logic [63:0]       ua, ub, x, y, r, q, limit;
         lcmo_pkg::rsp_type res;
         ua  = magnitude(w.operand_a);
         ub  = magnitude(w.operand_b);
         res = '0;
         if (ua == 0 || ub == 0)
            return res;
         // Euclid: x ends up holding gcd(ua, ub)
         x = ua;
         y = ub;
         while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
         end
         q             = ua / x;
         limit         = signed_mode ? MOST_POS : ALL_ONES;
         res.overflow  = (q > limit / ub);
         res.lcm_value = q * ub;
         return res;
      endfunction

      function void note_operands(lcmo_pkg::req_type w);
         predicted_lcm.push_back(lcm_of(w));
      endfunction

      function void check_result(lcmo_pkg::rsp_type got);
         lcmo_pkg::rsp_type want;
         if (predicted_lcm.size() == 0) begin
            $display("%0t: unexpected result word, got lcm %h ovf %b",
                     $time, got.lcm_value, got.overflow);
            errors++;
            return;
         end
         want = predicted_lcm.pop_front();
         if (got.lcm_value !== want.lcm_value) begin
            $display("%0t: lcm_value mismatch, expected %h actual %h",
                     $time, want.lcm_value, got.lcm_value);
            errors++;
         end
         if (got.overflow !== want.overflow) begin
            $display("%0t: overflow mismatch, expected %b actual %b",
                     $time, want.overflow, got.overflow);
            errors++;
         end
      endfunction

      function int outstanding();
         return predicted_lcm.size();
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // Clock, reset and block inputs (all known from time zero)
   // ---------------------------------------------------------------------
   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   lcmo_pkg::req_type req_data    = '0;
   logic              rsp_stall   = 1'b0;
   logic              csr_wr_en   = 1'b0;
   logic              csr_wr_data = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   lcmo_pkg::rsp_type rsp_data;

   // Idling knobs, set by the main sequence, read by the drivers
   int idle_pct  = 0;
   int stall_pct = 0;
   int hold_left = 0;

   lcm_scoreboard board = new;

   initial begin
      forever #5 clock = ~clock;
   end

   lcm_with_overflow_check_top #(
      .DATA_WIDTH (64)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // ---------------------------------------------------------------------
   // Result side: checks every accepted word, then picks next cycle's stall.
   // A pending hold-off is counted down here and forces stall high.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         board.check_result(rsp_data);
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offer one word, after a random run of idle cycles. Returns at the edge
   // that accepted it; valid is left high so a following word goes back to
   // back without a dip.
   task automatic offer(lcmo_pkg::req_type w, int gap_pct);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do
         @(posedge clock);
      while (req_stall);
      board.note_operands(w);
   endtask

   // Drop valid and wait for every predicted word to come back. Always
   // advances at least one edge, so valid is never lowered and raised in
   // the same step.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (board.outstanding() != 0);
   endtask

   // Mode write, only with the block empty and settled
   task automatic write_mode(bit m);
      wait_drained();
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.signed_mode = m;
   endtask

   function automatic logic [63:0] rand_bits();
      return {$urandom(), $urandom()};
   endfunction

   // Random operand pairs, biased towards shared factors, small values,
   // powers of two and products right on the overflow boundary.
   function automatic lcmo_pkg::req_type random_word(bit smode);
      logic [63:0]       a, b, g, t, lim;
      lcmo_pkg::req_type w;
      lim = smode ? MOST_POS : ALL_ONES;
      a   = rand_bits();
      b   = rand_bits();
      case ($urandom_range(9))
         0, 1: begin
         end
         2: begin
            a = $urandom_range(65535);
            b = $urandom_range(65535);
         end
         3: begin
            g = $urandom_range(1, 1 << 20);
            a = g * $urandom_range(1, 1 << 20);
            b = g * $urandom_range(1, 1 << 20);
         end
         4: begin
            // lcm lands around the mode's limit when the pair is coprime
            b = (rand_bits() >> $urandom_range(1, 62)) | 64'd1;
            a = lim / b + $urandom_range(0, 3) - 1;
         end
         5: begin
            a = 64'd1 << $urandom_range(63);
            b = $urandom_range(1) ? ALL_ONES : (64'd1 << $urandom_range(63));
         end
         6: begin
            if ($urandom_range(1))
               a = '0;
            else
               b = '0;
         end
         7: begin
            a = rand_bits() >> $urandom_range(0, 63);
            b = a * $urandom_range(1, 7);
         end
         default: begin
            a = rand_bits() >> $urandom_range(0, 63);
            b = rand_bits() >> $urandom_range(0, 63);
         end
      endcase
      if (smode && $urandom_range(3) == 0)
         a = -a;
      if (smode && $urandom_range(3) == 0)
         b = -b;
      if ($urandom_range(1)) begin
         t = a;
         a = b;
         b = t;
      end
      w.operand_a = a;
      w.operand_b = b;
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      lcmo_pkg::req_type directed[12];
      int                idle_tab[4];
      int                stall_tab[4];

      // edge cases, run once per mode: zero operands, unit, all ones,
      // most negative value, signed and unsigned boundaries, negatives
      directed[0]  = '{operand_a: 64'd0,       operand_b: MOST_NEG};
      directed[1]  = '{operand_a: 64'd5,       operand_b: 64'd0};
      directed[2]  = '{operand_a: 64'd1,       operand_b: 64'd1};
      directed[3]  = '{operand_a: ALL_ONES,    operand_b: ALL_ONES};
      directed[4]  = '{operand_a: MOST_NEG,    operand_b: 64'd1};
      directed[5]  = '{operand_a: MOST_NEG,    operand_b: MOST_NEG};
      directed[6]  = '{operand_a: MOST_NEG,    operand_b: 64'd3};
      directed[7]  = '{operand_a: MOST_POS,    operand_b: 64'd2};
      directed[8]  = '{operand_a: ALL_ONES,    operand_b: 64'd2};
      directed[9]  = '{operand_a: 64'h1_0000_0000, operand_b: 64'h1_0000_0001};
      directed[10] = '{operand_a: -64'sd4,     operand_b: 64'd6};
      directed[11] = '{operand_a: 64'd12,      operand_b: 64'd18};

      // idling per phase pair: none, sender, receiver, both
      idle_tab  = '{0, 76, 0, 16};
      stall_tab = '{0, 0, 76, 16};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // signed mode straight out of reset, then unsigned
      foreach (directed[i])
         offer(directed[i], 0);
      write_mode(1'b0);
      foreach (directed[i])
         offer(directed[i], 0);

      // random phases, alternating signed and unsigned under each idling mix
      for (int p = 0; p < 8; p++) begin
         write_mode((p % 2) == 0);
         idle_pct  = idle_tab[p / 2];
         stall_pct = stall_tab[p / 2];
         for (int i = 0; i < PHASE_LEN; i++) begin
            if (p == 2 && i == PHASE_LEN / 2) begin
               // receiver holds off while the sender keeps pushing,
               // so the block backs up and stalls its input
               hold_left = HOLD_LEN;
               repeat (12) offer(random_word(board.signed_mode), 0);
            end
            if (p == 5 && i == PHASE_LEN / 2)
               wait_drained();   // sender pauses until all results are back
            offer(random_word(board.signed_mode), idle_pct);
         end
      end

      wait_drained();
      repeat (SETTLE_LEN) @(posedge clock);

      if (board.errors == 0 && board.outstanding() == 0) begin
         $display("testbench: done, clean");
      end else begin
         if (board.outstanding() != 0)
            $display("%0t: %0d expected results never arrived",
                     $time, board.outstanding());
         $display("testbench: done, errors");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #30_000_000;
      $display("%0t: timeout", $time);
      $display("testbench: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
design/lcmo_pkg.sv
design/lcmo_dpath.sv
design/lcmo_ctrl.sv
design/lcm_with_overflow_check_top.sv
tb/testbench.sv
